### src/dwd_pkg.sv
// shared types and constants for the double-word by word divider
package dwd_pkg;

  localparam int MaxWordBits = 64;

  typedef struct packed {
    logic [MaxWordBits-1:0] high_word;
    logic [MaxWordBits-1:0] low_word;
    logic [MaxWordBits-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [MaxWordBits-1:0] quotient;
    logic [MaxWordBits-1:0] remainder;
    logic                   overflow;
  } rsp_t;

  // control that rides along with each word through the chain
  typedef struct packed {
    logic valid;
    logic overflow;
  } ctrl_t;

endpackage

### src/dwd_entry.sv
// entry stage: masks the input word and registers the overflow check
module dwd_entry #(
  parameter int WORD_BITS = dwd_pkg::MaxWordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 fire,
  input  dwd_pkg::req_t        req,
  output dwd_pkg::ctrl_t       ctrl,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] lo,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] div
);

  logic [WORD_BITS-1:0] hi_m;
  logic [WORD_BITS-1:0] div_m;

  assign hi_m  = req.high_word[WORD_BITS-1:0];
  assign div_m = req.divisor[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (adv) begin
      ctrl.valid    <= fire;
      ctrl.overflow <= (hi_m >= div_m);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= hi_m;
      lo  <= req.low_word[WORD_BITS-1:0];
      quo <= '0;
      div <= div_m;
    end
  end

endmodule

### src/dwd_cell.sv
// one restoring division step, registered
module dwd_cell #(
  parameter int WORD_BITS = dwd_pkg::MaxWordBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  dwd_pkg::ctrl_t       ctrl_in,
  input  logic [WORD_BITS-1:0] rem_in,
  input  logic [WORD_BITS-1:0] lo_in,
  input  logic [WORD_BITS-1:0] quo_in,
  input  logic [WORD_BITS-1:0] div_in,
  output dwd_pkg::ctrl_t       ctrl,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] lo,
  output logic [WORD_BITS-1:0] quo,
  output logic [WORD_BITS-1:0] div
);

  logic [WORD_BITS:0] shifted;
  logic [WORD_BITS:0] diff;
  logic               take;

  // partial remainder shifted left with the next dividend bit, one bit wider
  assign shifted = {rem_in, lo_in[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, div_in};
  assign take    = !diff[WORD_BITS] || (shifted < {1'b0, div_in}) == 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (adv) begin
      ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= take ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      lo  <= {lo_in[WORD_BITS-2:0], 1'b0};
      quo <= {quo_in[WORD_BITS-2:0], take};
      div <= div_in;
    end
  end

endmodule

### src/double_word_by_word_divider_top.sv
// top level: entry stage, chain of division cells and output register
//
// Divides {high_word, low_word} by divisor and returns a one-word quotient
// and remainder. Both channels use valid/ready; a word moves when valid and
// ready are high at a rising edge of clk.
// A word enters in every cycle while the chain is not held. Each request
// passes an entry stage, one cell per quotient bit (WORD_BITS cells) and
// an output register. The accepting edge loads the entry stage, and the
// word then moves through the cells into the output register while the
// chain keeps moving; the cell count sets the latency, each cell holds one
// compare-and-subtract of WORD_BITS + 1 bits.
// When high_word >= divisor (a zero divisor included) the response carries
// overflow = 1 with zero quotient and remainder. Input bits above WORD_BITS
// are ignored and output bits above WORD_BITS are zero.
// While the response register holds a word that is not taken, the whole
// chain holds and req_ready is low; requests already in flight are kept.
// Synchronous reset on rst empties the chain and the output register.
module double_word_by_word_divider_top #(
  parameter int WORD_BITS = dwd_pkg::MaxWordBits
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dwd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output dwd_pkg::rsp_t rsp
);

  localparam int PadBits = dwd_pkg::MaxWordBits - WORD_BITS;

  logic adv;
  logic fire;

  dwd_pkg::ctrl_t       ctrl [0:WORD_BITS];
  logic [WORD_BITS-1:0] rem  [0:WORD_BITS];
  logic [WORD_BITS-1:0] lo   [0:WORD_BITS];
  logic [WORD_BITS-1:0] quo  [0:WORD_BITS];
  logic [WORD_BITS-1:0] div  [0:WORD_BITS];

  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;
  assign fire      = req_valid && adv;

  dwd_entry #(.WORD_BITS(WORD_BITS)) u_entry (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .fire (fire),
    .req  (req),
    .ctrl (ctrl[0]),
    .rem  (rem[0]),
    .lo   (lo[0]),
    .quo  (quo[0]),
    .div  (div[0])
  );

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    dwd_cell #(.WORD_BITS(WORD_BITS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctrl_in (ctrl[i]),
      .rem_in  (rem[i]),
      .lo_in   (lo[i]),
      .quo_in  (quo[i]),
      .div_in  (div[i]),
      .ctrl    (ctrl[i+1]),
      .rem     (rem[i+1]),
      .lo      (lo[i+1]),
      .quo     (quo[i+1]),
      .div     (div[i+1])
    );
  end

  logic [WORD_BITS-1:0] quo_out;
  logic [WORD_BITS-1:0] rem_out;

  // overflowed words leave the chain with their fields forced to zero
  assign quo_out = ctrl[WORD_BITS].overflow ? '0 : quo[WORD_BITS];
  assign rem_out = ctrl[WORD_BITS].overflow ? '0 : rem[WORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= ctrl[WORD_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.quotient  <= {{PadBits{1'b0}}, quo_out};
      rsp.remainder <= {{PadBits{1'b0}}, rem_out};
      rsp.overflow  <= ctrl[WORD_BITS].overflow;
    end
  end

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.overflow |-> rsp.quotient == '0 && rsp.remainder == '0)
    else $error("overflow response with nonzero fields");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctrl[WORD_BITS]) && $stable(ctrl[0]) && rsp_valid)
    else $error("chain moved during a stall");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    adv && ctrl[WORD_BITS].valid |=> rsp_valid)
    else $error("word lost at the end of the chain");

endmodule
